### design/sled_pkg.sv
// package for the serpentine lite error diffusion core
// shared types, codes and default sizes; no dependencies
`timescale 1ns / 1ps

package sled_pkg;

  // default sizes handed to the top level
  localparam int MAX_WIDTH_DEF    = 1024;
  localparam int CHANNEL_BITS_DEF = 7;

  // widest column index the block supports (MAX_WIDTH up to 4096)
  localparam int XW_MAX      = 12;
  // stored error per channel: two quarter shares of a 9-bit difference
  localparam int ERR_BITS    = 8;
  // entries in the queue between front and back
  localparam int QUEUE_DEPTH = 4;

  // reset values of the geometry registers
  localparam logic [10:0] WIDTH_RESET  = 11'd1024;
  localparam logic [15:0] HEIGHT_RESET = 16'd1;

  // configuration register indexes
  localparam logic REG_IMAGE_WIDTH  = 1'b0;
  localparam logic REG_IMAGE_HEIGHT = 1'b1;

  // item kinds carried on s_tuser
  typedef enum logic [1:0] {
    OP_LOAD_NEAREST = 2'd0,
    OP_LOAD_INDEX   = 2'd1,
    OP_DITHER       = 2'd2
  } op_t;

  // back-end sequencer states
  typedef enum logic [1:0] {
    ST_FETCH,
    ST_MIX,
    ST_LOOK,
    ST_TAIL
  } back_state_t;

  // classified item passed from front to back
  typedef struct packed {
    op_t                op;
    logic [20:0]        addr;
    logic [23:0]        data;
    logic [XW_MAX-1:0]  x;
    logic               first_row;
    logic               first_col;
    logic               last_col;
    logic               last_row;
    logic               odd;
  } item_t;

endpackage

### design/sled_ram.sv
// generic single-write, single-read memory with registered read data
// depends on nothing
`timescale 1ns / 1ps

module sled_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### design/sled_queue.sv
// short queue of classified items between front and back
// depends on sled_pkg
`timescale 1ns / 1ps

module sled_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  sled_pkg::item_t push_item,
  output logic            full,
  input  logic            pop,
  output sled_pkg::item_t head,
  output logic            valid
);

  localparam int DEPTH = sled_pkg::QUEUE_DEPTH;
  localparam int PW    = $clog2(DEPTH);
  localparam int CW    = $clog2(DEPTH + 1);

  sled_pkg::item_t slots [DEPTH];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic [CW-1:0]   count;

  assign full  = count == CW'(DEPTH);
  assign valid = count != '0;
  assign head  = slots[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

### design/sled_front.sv
// front end: geometry registers, input transfers, pixel position tracking
// depends on sled_pkg
`timescale 1ns / 1ps

module sled_front #(
  parameter int MAX_WIDTH = sled_pkg::MAX_WIDTH_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_wr_en,
  input  logic            cfg_addr,
  input  logic [15:0]     cfg_wdata,
  input  logic            s_tvalid,
  output logic            s_tready,
  input  logic [71:0]     s_tdata,
  input  logic [1:0]      s_tuser,
  input  logic            q_full,
  output logic            q_push,
  output sled_pkg::item_t q_item
);

  localparam int XW = $clog2(MAX_WIDTH);

  logic [10:0]      image_width;
  logic [15:0]      image_height;
  logic [XW-1:0]    column_count;
  logic [15:0]      row_count;
  logic [XW-1:0]    wm1;
  logic [15:0]      hm1;
  logic [XW-1:0]    x;
  logic             last_col;
  logic             last_row;
  logic             accept;
  sled_pkg::op_t    op;

  assign s_tready = !q_full;
  assign accept   = s_tvalid && s_tready;
  assign op       = sled_pkg::op_t'(s_tuser);

  // effective geometry: zero acts as one, width capped at the line store size
  always_comb begin
    if (image_width == '0) begin
      wm1 = '0;
    end else if (32'(image_width) > MAX_WIDTH) begin
      wm1 = XW'(MAX_WIDTH - 1);
    end else begin
      wm1 = XW'(image_width - 11'd1);
    end
    hm1 = (image_height == '0) ? '0 : image_height - 16'd1;
  end

  // position of this pixel, serpentine on odd rows
  assign last_col = column_count == wm1;
  assign last_row = row_count >= hm1;
  assign x        = row_count[0] ? wm1 - column_count : column_count;

  // classify the item
  always_comb begin
    q_item           = '0;
    q_item.op        = op;
    q_item.addr      = s_tdata[20:0];
    q_item.data      = (op == sled_pkg::OP_DITHER) ? s_tdata[68:45] : s_tdata[44:21];
    q_item.x[XW-1:0] = x;
    q_item.first_row = row_count == '0;
    q_item.first_col = column_count == '0;
    q_item.last_col  = last_col;
    q_item.last_row  = last_row;
    q_item.odd       = row_count[0];
    q_push = accept && (op inside {sled_pkg::OP_LOAD_NEAREST, sled_pkg::OP_LOAD_INDEX,
                                   sled_pkg::OP_DITHER});
  end

  // geometry registers and frame counters
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= sled_pkg::WIDTH_RESET;
      image_height <= sled_pkg::HEIGHT_RESET;
      column_count <= '0;
      row_count    <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_addr)
        sled_pkg::REG_IMAGE_WIDTH:  image_width  <= cfg_wdata[10:0];
        sled_pkg::REG_IMAGE_HEIGHT: image_height <= cfg_wdata;
        default: ;
      endcase
      column_count <= '0;
      row_count    <= '0;
    end else if (accept && op == sled_pkg::OP_DITHER) begin
      if (last_col) begin
        column_count <= '0;
        row_count    <= last_row ? '0 : row_count + 16'd1;
      end else begin
        column_count <= column_count + 1'b1;
      end
    end
  end

endmodule

### design/sled_back.sv
// back end: table loads, error mixing, nearest colour and index lookups
// depends on sled_pkg and sled_ram
`timescale 1ns / 1ps

module sled_back #(
  parameter int MAX_WIDTH    = sled_pkg::MAX_WIDTH_DEF,
  parameter int CHANNEL_BITS = sled_pkg::CHANNEL_BITS_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_wr_en,
  input  logic            q_valid,
  input  sled_pkg::item_t q_head,
  output logic            q_pop,
  output logic            m_tvalid,
  input  logic            m_tready,
  output logic [7:0]      m_tdata,
  output logic            m_tlast,
  output logic            m_tuser
);

  localparam int XW  = $clog2(MAX_WIDTH);
  localparam int TAW = 3 * CHANNEL_BITS;
  localparam int EW  = sled_pkg::ERR_BITS;

  sled_pkg::back_state_t state;
  sled_pkg::back_state_t state_next;
  sled_pkg::item_t       item;

  logic [7:0]        val [3];
  logic [7:0]        val_next [3];
  logic signed [7:0] carry [3];
  logic signed [6:0] q_prev [3];
  logic [XW-1:0]     prev_x;
  logic              out_valid;
  logic              out_last;
  logic              out_frame;

  logic              err_rd_en;
  logic              near_rd_en;
  logic              look_go;
  logic              tail_go;
  logic              near_wr_en;
  logic              pal_wr_en;
  logic              err_wr_en;
  logic [XW:0]       err_wr_addr;
  logic [3*EW-1:0]   err_wr_data;
  logic [3*EW-1:0]   err_rd_data;
  logic [23:0]       near_rd_data;
  logic [TAW-1:0]    near_addr;
  logic [TAW-1:0]    pal_addr;

  logic signed [9:0] mix [3];
  logic signed [7:0] err_in [3];
  logic signed [8:0] delta [3];
  logic signed [7:0] half [3];
  logic signed [6:0] quarter [3];
  logic [3*EW-1:0]   pair_sum;
  logic [3*EW-1:0]   tail_word;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      sled_pkg::ST_FETCH: begin
        if (q_valid && q_head.op == sled_pkg::OP_DITHER) begin
          state_next = sled_pkg::ST_MIX;
        end
      end
      sled_pkg::ST_MIX: state_next = sled_pkg::ST_LOOK;
      sled_pkg::ST_LOOK: begin
        if (!out_valid || m_tready) begin
          state_next = item.last_col ? sled_pkg::ST_TAIL : sled_pkg::ST_FETCH;
        end
      end
      sled_pkg::ST_TAIL: state_next = sled_pkg::ST_FETCH;
      default: state_next = sled_pkg::ST_FETCH;
    endcase
  end

  // per-state strobes
  always_comb begin
    q_pop      = 1'b0;
    err_rd_en  = 1'b0;
    near_rd_en = 1'b0;
    look_go    = 1'b0;
    tail_go    = 1'b0;
    case (state)
      sled_pkg::ST_FETCH: begin
        q_pop     = q_valid;
        err_rd_en = q_valid && q_head.op == sled_pkg::OP_DITHER;
      end
      sled_pkg::ST_MIX:  near_rd_en = 1'b1;
      sled_pkg::ST_LOOK: look_go    = !out_valid || m_tready;
      sled_pkg::ST_TAIL: tail_go    = 1'b1;
      default: ;
    endcase
  end

  assign near_wr_en = q_pop && q_head.op == sled_pkg::OP_LOAD_NEAREST;
  assign pal_wr_en  = q_pop && q_head.op == sled_pkg::OP_LOAD_INDEX;

  // add row error and carried error, clamp, form the nearest table address
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      err_in[c]   = item.first_row ? '0 : $signed(err_rd_data[EW*(2-c) +: EW]);
      mix[c]      = $signed({2'b00, item.data[8*(2-c) +: 8]})
                    + {{2{err_in[c][7]}}, err_in[c]} + {{2{carry[c][7]}}, carry[c]};
      if (mix[c][9]) begin
        val_next[c] = 8'd0;
      end else if (mix[c][8]) begin
        val_next[c] = 8'd255;
      end else begin
        val_next[c] = mix[c][7:0];
      end
      near_addr[CHANNEL_BITS*(2-c) +: CHANNEL_BITS] = val_next[c][7 -: CHANNEL_BITS];
    end
  end

  // quantisation error and its shares
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      delta[c]   = $signed({1'b0, val[c]}) - $signed({1'b0, near_rd_data[8*(2-c) +: 8]});
      half[c]    = 8'(delta[c] >>> 1);
      quarter[c] = 7'(delta[c] >>> 2);
      pair_sum[EW*(2-c) +: EW]  = {q_prev[c][6], q_prev[c]} + {quarter[c][6], quarter[c]};
      tail_word[EW*(2-c) +: EW] = {q_prev[c][6], q_prev[c]};
      pal_addr[CHANNEL_BITS*(2-c) +: CHANNEL_BITS] = near_rd_data[8*(2-c)+7 -: CHANNEL_BITS];
    end
  end

  // line store write: the previous pixel's entry is final once this pixel is done
  always_comb begin
    err_wr_en   = (look_go && !item.first_col) || tail_go;
    err_wr_addr = {item.odd, tail_go ? item.x[XW-1:0] : prev_x};
    err_wr_data = tail_go ? tail_word : pair_sum;
  end

  // nearest colour table
  sled_ram #(
    .WIDTH (24),
    .DEPTH (1 << TAW)
  ) u_near_ram (
    .clk     (clk),
    .wr_en   (near_wr_en),
    .wr_addr (q_head.addr[TAW-1:0]),
    .wr_data (q_head.data),
    .rd_en   (near_rd_en),
    .rd_addr (near_addr),
    .rd_data (near_rd_data)
  );

  // palette index table, read data drives the output
  sled_ram #(
    .WIDTH (8),
    .DEPTH (1 << TAW)
  ) u_pal_ram (
    .clk     (clk),
    .wr_en   (pal_wr_en),
    .wr_addr (q_head.addr[TAW-1:0]),
    .wr_data (q_head.data[7:0]),
    .rd_en   (look_go),
    .rd_addr (pal_addr),
    .rd_data (m_tdata)
  );

  // row error line store, two banks chosen by row parity
  sled_ram #(
    .WIDTH (3 * EW),
    .DEPTH (2 * MAX_WIDTH)
  ) u_err_ram (
    .clk     (clk),
    .wr_en   (err_wr_en),
    .wr_addr (err_wr_addr),
    .wr_data (err_wr_data),
    .rd_en   (err_rd_en),
    .rd_addr ({~q_head.odd, q_head.x[XW-1:0]}),
    .rd_data (err_rd_data)
  );

  // item and datapath registers
  always_ff @(posedge clk) begin
    if (q_pop) begin
      item <= q_head;
    end
    if (near_rd_en) begin
      val <= val_next;
    end
    if (look_go) begin
      q_prev    <= quarter;
      prev_x    <= item.x[XW-1:0];
      out_last  <= item.last_col;
      out_frame <= item.last_col && item.last_row;
    end
  end

  // state, carried error and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= sled_pkg::ST_FETCH;
      out_valid <= 1'b0;
      for (int c = 0; c < 3; c++) begin
        carry[c] <= '0;
      end
    end else begin
      state <= state_next;
      if (cfg_wr_en) begin
        for (int c = 0; c < 3; c++) begin
          carry[c] <= '0;
        end
      end else if (look_go) begin
        for (int c = 0; c < 3; c++) begin
          carry[c] <= item.last_col ? '0 : half[c];
        end
      end
      if (look_go) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign m_tvalid = out_valid;
  assign m_tlast  = out_last;
  assign m_tuser  = out_frame;

endmodule

### design/serpentine_lite_error_diffusion_core.sv
// top level of the serpentine lite error diffusion ditherer
// depends on sled_pkg, sled_front, sled_queue, sled_back (and sled_ram below it)
`timescale 1ns / 1ps

// Usage
// - s_* stream carries load and pixel items; s_tuser gives the kind (nearest
//   colour load, palette index load, dither pixel; the fourth code is dropped)
// - m_* stream gives one palette index per pixel, m_tlast on the last pixel
//   of a row, m_tuser on the last pixel of the frame
// - cfg port writes image width (index 0), height (index 1); the user must write
//   only while idle (not enforced by the block); either write restarts the frame
// - a load is done in the fetch state; a pixel steps through fetch, mix and
//   look, and tail on the last pixel of a row, before the next item is
//   fetched, as the carried error runs through the nearest colour table read
//   back into the next pixel's sum
// - a 4-entry queue lets input transfers continue while the back end works or
//   the output waits; a held result stalls the back end, then the queue fills
// - reset clears the queue, the output, the position counters and the
//   carried error and sets width 1024, height 1; the colour tables are not
//   cleared and hold nothing valid until loaded
// - the line error store needs no clearing: each row rewrites every entry
//   and the first row of a frame reads as zero
module serpentine_lite_error_diffusion_core #(
  parameter int MAX_WIDTH    = sled_pkg::MAX_WIDTH_DEF,
  parameter int CHANNEL_BITS = sled_pkg::CHANNEL_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic        cfg_addr,
  input  logic [15:0] cfg_wdata,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [71:0] s_tdata,   // table_address, table_value, pixel_rgb, zero pad
  input  logic [1:0]  s_tuser,   // operation
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // color_index
  output logic        m_tlast,   // row_end
  output logic        m_tuser    // frame_end
);

  sled_pkg::item_t push_item;
  sled_pkg::item_t head;
  logic            push;
  logic            full;
  logic            pop;
  logic            head_valid;

  // accept and classify items
  sled_front #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .q_full    (full),
    .q_push    (push),
    .q_item    (push_item)
  );

  // decoupling queue
  sled_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .full      (full),
    .pop       (pop),
    .head      (head),
    .valid     (head_valid)
  );

  // execute loads and dither pixels
  sled_back #(
    .MAX_WIDTH    (MAX_WIDTH),
    .CHANNEL_BITS (CHANNEL_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .q_valid   (head_valid),
    .q_head    (head),
    .q_pop     (pop),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .m_tuser   (m_tuser)
  );

endmodule

### design/sled_checker.sv
// port-level checks for the serpentine lite error diffusion core
// depends on serpentine_lite_error_diffusion_core (bound to it)
`timescale 1ns / 1ps

module sled_checker (
  input logic       clk,
  input logic       rst,
  input logic       s_tready,
  input logic       m_tvalid,
  input logic       m_tready,
  input logic [7:0] m_tdata,
  input logic       m_tlast,
  input logic       m_tuser
);

  // frame end only on the last pixel of a row
  a_frame_on_row_end: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tlast)
    else $error("frame end without row end");

  // reset empties the output stage
  a_reset_clears_out: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result pending after reset");

  // reset empties the queue, so input is taken at once
  a_reset_ready: assert property (@(posedge clk) rst |=> s_tready)
    else $error("input not ready after reset");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)
      && $stable(m_tuser))
    else $error("stalled result changed");

endmodule

bind serpentine_lite_error_diffusion_core sled_checker u_sled_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast),
  .m_tuser  (m_tuser)
);

### dv/tb.sv
// self-checking testbench for serpentine_lite_error_diffusion_core
// depends on sled_pkg and the core; carries its own dither predictor
`timescale 1ns / 1ps

module tb;

  localparam logic [1:0] OP_IGNORED = 2'd3;
  localparam int WMAX = 1024;
  localparam int CYCLE_LIMIT = 400000;
  localparam int RANDOM_ITEMS = 1150;

  typedef struct {
    logic [7:0] idx;
    logic       row_end;
    logic       frame_end;
  } dither_out_t;

  typedef enum logic [1:0] {ROW_ITEM, ROW_REG} row_kind_t;

  typedef struct {
    row_kind_t   kind;
    logic [1:0]  op;
    logic [20:0] addr;
    logic [23:0] value;
    logic [23:0] pix;
    logic        typed;
    dither_out_t res;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_wr_en = 1'b0;
  logic        cfg_addr = 1'b0;
  logic [15:0] cfg_wdata = '0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [71:0] s_tdata = '0;   // table_address, table_value, pixel_rgb, zero pad
  logic [1:0]  s_tuser = '0;   // operation
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;        // color_index
  logic        m_tlast;        // row_end
  logic        m_tuser;        // frame_end

  serpentine_lite_error_diffusion_core dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state
  logic [23:0] nearest_colour[int];
  logic [7:0]  palette_idx[int];
  int          row_err[WMAX][3];
  int          below_err[WMAX][3];
  int          carry_err[3];
  int          col_pos, row_pos;
  logic [10:0] width_reg = sled_pkg::WIDTH_RESET;
  logic [15:0] height_reg = sled_pkg::HEIGHT_RESET;

  dither_out_t pending_idx[$];
  int  mismatches = 0;
  int  results_seen = 0;
  int  items_sent = 0;
  int  cycles = 0;
  int  idle_mode = 0;   // 0: sender light, receiver heavy; 1: reversed; 2: none

  function automatic logic [20:0] colour_addr(int r, int g, int b);
    return {r[7:1], g[7:1], b[7:1]};
  endfunction

  function automatic int eff_width();
    int w;
    w = (width_reg == 0) ? 1 : int'(width_reg);
    return (w > WMAX) ? WMAX : w;
  endfunction

  function automatic int column_of();
    int w;
    w = eff_width();
    if (col_pos >= w) col_pos = w - 1;
    return row_pos[0] ? (w - 1 - col_pos) : col_pos;
  endfunction

  // channel values after adding the diffused error, clamped to 0..255
  function automatic void clamped_rgb(logic [23:0] pix, output int v[3]);
    int x, t;
    x = column_of();
    for (int c = 0; c < 3; c++) begin
      t = int'(pix[16 - 8 * c +: 8]) + row_err[x][c] + carry_err[c];
      v[c] = (t > 255) ? 255 : ((t < 0) ? 0 : t);
    end
  endfunction

  function automatic void restart_frame();
    for (int i = 0; i < WMAX; i++)
      for (int c = 0; c < 3; c++) begin
        row_err[i][c] = 0;
        below_err[i][c] = 0;
      end
    carry_err = '{0, 0, 0};
    col_pos = 0;
    row_pos = 0;
  endfunction

  // one dither step: result and error spreading
  function automatic dither_out_t dither_step(logic [23:0] pix);
    int v[3], w, h, x, q, d;
    logic [23:0] near;
    logic last_col, last_row;
    dither_out_t o;
    w = eff_width();
    h = (height_reg == 0) ? 1 : int'(height_reg);
    x = column_of();
    last_col = (col_pos == w - 1);
    last_row = (row_pos >= h - 1);
    clamped_rgb(pix, v);
    near = nearest_colour[colour_addr(v[0], v[1], v[2])];
    for (int c = 0; c < 3; c++) begin
      d = v[c] - int'(near[16 - 8 * c +: 8]);
      carry_err[c] = last_col ? 0 : (d >>> 1);
      if (!last_row) begin
        q = d >>> 2;
        below_err[x][c] += q;
        if (!row_pos[0]) begin
          if (x > 0) below_err[x - 1][c] += q;
        end else if (x < w - 1) begin
          below_err[x + 1][c] += q;
        end
      end
    end
    o.idx = palette_idx[colour_addr(near[23:16], near[15:8], near[7:0])];
    o.row_end = last_col;
    o.frame_end = last_col && last_row;
    if (last_col) begin
      if (last_row) begin
        restart_frame();
      end else begin
        for (int i = 0; i < WMAX; i++)
          for (int c = 0; c < 3; c++) begin
            row_err[i][c] = below_err[i][c];
            below_err[i][c] = 0;
          end
        carry_err = '{0, 0, 0};
        col_pos = 0;
        row_pos = (row_pos + 1) & 16'hFFFF;
      end
    end else begin
      col_pos++;
    end
    return o;
  endfunction

  // one input transfer; the predictor follows on acceptance
  task automatic send_item(logic [1:0] op, logic [20:0] addr, logic [23:0] value,
                           logic [23:0] pix, logic typed, dither_out_t typed_res);
    dither_out_t o;
    int gap_pct;
    gap_pct = (idle_mode == 0) ? 24 : ((idle_mode == 1) ? 76 : 0);
    while ($urandom_range(99) < gap_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tdata  <= {3'b000, pix, value, addr};
    s_tuser  <= op;
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
    items_sent++;
    case (op)
      sled_pkg::OP_LOAD_NEAREST: nearest_colour[addr] = value;
      sled_pkg::OP_LOAD_INDEX:   palette_idx[addr] = value[7:0];
      sled_pkg::OP_DITHER: begin
        o = dither_step(pix);
        pending_idx.push_back(typed ? typed_res : o);
      end
      default: ;
    endcase
  endtask

  // pixel, preceded by whatever table loads keep its lookups on written entries
  task automatic send_pixel(logic [23:0] pix);
    int v[3];
    logic [20:0] a;
    logic [23:0] near;
    dither_out_t none;
    none = '{8'h00, 1'b0, 1'b0};
    clamped_rgb(pix, v);
    a = colour_addr(v[0], v[1], v[2]);
    if (!nearest_colour.exists(a))
      send_item(sled_pkg::OP_LOAD_NEAREST, a, 24'($urandom_range(24'hFFFFFF)), '0, 1'b0,
                none);
    near = nearest_colour[a];
    a = colour_addr(near[23:16], near[15:8], near[7:0]);
    if (!palette_idx.exists(a))
      send_item(sled_pkg::OP_LOAD_INDEX, a, 24'($urandom_range(24'hFFFFFF)), '0, 1'b0,
                none);
    send_item(sled_pkg::OP_DITHER, 21'($urandom_range(21'h1FFFFF)),
              24'($urandom_range(24'hFFFFFF)), pix, 1'b0, none);
  endtask

  // register write once the block has drained
  task automatic write_reg(logic idx, logic [15:0] value);
    s_tvalid <= 1'b0;
    while (pending_idx.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    if (idx == sled_pkg::REG_IMAGE_WIDTH) width_reg = value[10:0];
    else height_reg = value;
    restart_frame();
  endtask

  // receiver side: random back-pressure
  always @(posedge clk) begin
    case (idle_mode)
      0:       m_tready <= ($urandom_range(99) >= 76);
      1:       m_tready <= ($urandom_range(99) >= 24);
      default: m_tready <= 1'b1;
    endcase
  end

  // compare each result transfer with the oldest expectation
  always @(posedge clk) begin
    dither_out_t e;
    if (!rst && m_tvalid && m_tready) begin
      results_seen++;
      if (pending_idx.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: idx %h last %b frame %b", m_tdata, m_tlast, m_tuser);
      end else begin
        e = pending_idx.pop_front();
        if (m_tdata !== e.idx || m_tlast !== e.row_end || m_tuser !== e.frame_end) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected idx %h last %b frame %b, got %h %b %b",
                     e.idx, e.row_end, e.frame_end, m_tdata, m_tlast, m_tuser);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: FAIL");
      $finish;
    end
  end

  stim_row_t directed[$];
  int widths[8]  = '{1, 2, 3, 16, 0, 2047, 7, 1024};
  int heights[8] = '{1, 2, 5, 3, 0, 1, 65535, 2};

  initial begin
    int seg, npix;
    logic [23:0] p;
    dither_out_t none;
    none = '{8'h00, 1'b0, 1'b0};
    restart_frame();

    // directed table: extremes of address and value, ignored code, row and frame ends
    directed = '{
      '{ROW_ITEM, sled_pkg::OP_LOAD_NEAREST, 21'h000000, 24'h000000, 24'h0, 1'b0, none},
      '{ROW_ITEM, sled_pkg::OP_LOAD_INDEX,   21'h000000, 24'hFFFF5A, 24'h0, 1'b0, none},
      '{ROW_ITEM, sled_pkg::OP_LOAD_NEAREST, 21'h1FFFFF, 24'hFFFFFF, 24'h0, 1'b0, none},
      '{ROW_ITEM, sled_pkg::OP_LOAD_INDEX,   21'h1FFFFF, 24'h0000A5, 24'h0, 1'b0, none},
      '{ROW_ITEM, OP_IGNORED,      21'h1FFFFF, 24'hFFFFFF, 24'hFFFFFF, 1'b0, none},
      '{ROW_ITEM, sled_pkg::OP_DITHER,       21'h1FFFFF, 24'hFFFFFF, 24'h000000, 1'b1,
        '{8'h5A, 1'b0, 1'b0}},
      '{ROW_ITEM, sled_pkg::OP_DITHER,       21'h000000, 24'h000000, 24'hFFFFFF, 1'b1,
        '{8'hA5, 1'b0, 1'b0}},
      '{ROW_ITEM, sled_pkg::OP_DITHER, 21'h0, 24'h0, 24'h010101, 1'b1, '{8'h5A, 1'b0, 1'b0}},
      '{ROW_ITEM, sled_pkg::OP_DITHER, 21'h0, 24'h0, 24'h808080, 1'b0, none},
      '{ROW_ITEM, sled_pkg::OP_DITHER, 21'h0, 24'h0, 24'hFF0000, 1'b0, none},
      '{ROW_REG,  2'd0, 21'(sled_pkg::REG_IMAGE_WIDTH), 24'd1, 24'h0, 1'b0, none},
      '{ROW_REG,  2'd0, 21'(sled_pkg::REG_IMAGE_HEIGHT), 24'd2, 24'h0, 1'b0, none},
      '{ROW_ITEM, sled_pkg::OP_DITHER, 21'h0, 24'h0, 24'h000000, 1'b1, '{8'h5A, 1'b1, 1'b0}},
      '{ROW_ITEM, sled_pkg::OP_DITHER, 21'h0, 24'h0, 24'hFFFFFF, 1'b1, '{8'hA5, 1'b1, 1'b1}},
      '{ROW_ITEM, sled_pkg::OP_DITHER, 21'h0, 24'h0, 24'h00FF00, 1'b0, none},
      '{ROW_ITEM, sled_pkg::OP_DITHER, 21'h0, 24'h0, 24'h0000FF, 1'b0, none},
      '{ROW_ITEM, sled_pkg::OP_DITHER, 21'h0, 24'h0, 24'h7F7F7F, 1'b0, none},
      '{ROW_REG,  2'd0, 21'(sled_pkg::REG_IMAGE_HEIGHT), 24'd0, 24'h0, 1'b0, none},
      '{ROW_ITEM, sled_pkg::OP_DITHER, 21'h0, 24'h0, 24'h000000, 1'b1, '{8'h5A, 1'b1, 1'b1}}
    };

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed[i]) begin
      if (directed[i].kind == ROW_REG)
        write_reg(directed[i].addr[0], directed[i].value[15:0]);
      else if (directed[i].op == sled_pkg::OP_DITHER && !directed[i].typed)
        send_pixel(directed[i].pix);
      else
        send_item(directed[i].op, directed[i].addr, directed[i].value, directed[i].pix,
                  directed[i].typed, directed[i].res);
    end

    // random part: a run of pixels per geometry, with loads and ignored codes mixed in
    seg = 0;
    while (items_sent < RANDOM_ITEMS) begin
      idle_mode = (items_sent < 420) ? 0 : ((items_sent < 820) ? 1 : 2);
      if (seg % 2) begin
        write_reg(sled_pkg::REG_IMAGE_HEIGHT, 16'(heights[seg % 8]));
        write_reg(sled_pkg::REG_IMAGE_WIDTH, 16'(widths[seg % 8]));
      end else begin
        write_reg(sled_pkg::REG_IMAGE_WIDTH, 16'(widths[seg % 8]));
        write_reg(sled_pkg::REG_IMAGE_HEIGHT, 16'(heights[seg % 8]));
      end
      npix = $urandom_range(20, 110);
      for (int n = 0; n < npix && items_sent < RANDOM_ITEMS; n++) begin
        case ($urandom_range(19))
          0: send_item(sled_pkg::OP_LOAD_NEAREST, 21'($urandom_range(21'h1FFFFF)),
                       24'($urandom_range(24'hFFFFFF)), '0, 1'b0, none);
          1: send_item(sled_pkg::OP_LOAD_INDEX, 21'($urandom_range(21'h1FFFFF)),
                       24'($urandom_range(24'hFFFFFF)), '0, 1'b0, none);
          2: send_item(OP_IGNORED, 21'($urandom_range(21'h1FFFFF)),
                       24'($urandom_range(24'hFFFFFF)), 24'($urandom_range(24'hFFFFFF)),
                       1'b0, none);
          default: ;
        endcase
        case ($urandom_range(7))
          0: p = 24'h000000;
          1: p = 24'hFFFFFF;
          default: p = 24'($urandom_range(24'hFFFFFF));
        endcase
        send_pixel(p);
      end
      seg++;
    end

    // drain
    s_tvalid <= 1'b0;
    while (pending_idx.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    $display("covered %0d input transfers and %0d pixel results over %0d geometries",
             items_sent, results_seen, seg + 3);
    $display("mismatches: %0d", mismatches);
    if (mismatches == 0 && pending_idx.size() == 0)
      $display("tb: PASS");
    else
      $display("tb: FAIL");
    $finish;
  end

endmodule

### sim.f
design/sled_pkg.sv
design/sled_ram.sv
design/sled_queue.sv
design/sled_front.sv
design/sled_back.sv
design/serpentine_lite_error_diffusion_core.sv
design/sled_checker.sv
dv/tb.sv
